@@ rtl/ppfq_pkg.sv @@
// Shared types and constants of the per-priority FIFO queue.
`timescale 1ns / 1ps

package ppfq_pkg;

    localparam int LEVEL_W     = 4;
    localparam int WORD_W      = 32;
    localparam int STATUS_W    = 2;
    localparam int LEVEL_LIMIT = 2 ** LEVEL_W;
    localparam int QUEUE_DEPTH = 4;

    localparam logic CMD_PUSH = 1'b0;
    localparam logic CMD_POP  = 1'b1;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;

    typedef enum logic [1:0] {
        OP_NONE,
        OP_WRITE,
        OP_READ
    } t_op;

    typedef struct packed {
        t_op                 op;
        logic [STATUS_W-1:0] status;
    } t_job;

endpackage

@@ rtl/ppfq_front.sv @@
// Front end: accepts items, keeps per-level head and count, and turns each item into a job.
`timescale 1ns / 1ps

module ppfq_front
    import ppfq_pkg::*;
#(
    parameter  int ACTIVE_LEVELS = 16,
    parameter  int DEPTH         = 16,
    localparam int ADDR_W        = $clog2(ACTIVE_LEVELS * DEPTH)
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_cmd,
    input  logic [LEVEL_W-1:0] i_level,
    input  logic [WORD_W-1:0]  i_word,
    input  logic               i_q_full,
    output logic               o_ready,
    output logic               o_push,
    output t_job               o_job,
    output logic [ADDR_W-1:0]  o_addr,
    output logic [WORD_W-1:0]  o_word
);

    localparam int IDX_W  = $clog2(ACTIVE_LEVELS);
    localparam int HEAD_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int SUM_W  = HEAD_W + 1;
    localparam logic [LEVEL_W:0] LEVEL_END = (LEVEL_W + 1)'(ACTIVE_LEVELS);

    logic [HEAD_W-1:0] r_head  [ACTIVE_LEVELS];
    logic [CNT_W-1:0]  r_count [ACTIVE_LEVELS];

    logic              accept;
    logic              level_ok;
    logic [IDX_W-1:0]  idx;
    logic [HEAD_W-1:0] cur_head;
    logic [CNT_W-1:0]  cur_count;
    logic [SUM_W-1:0]  tail_sum;
    logic [SUM_W-1:0]  next_sum;
    logic [HEAD_W-1:0] tail_slot;
    logic [HEAD_W-1:0] next_head;
    logic [HEAD_W-1:0] slot;
    logic              upd;
    logic [HEAD_W-1:0] n_head;
    logic [CNT_W-1:0]  n_count;

    assign o_ready  = !i_q_full;
    assign accept   = i_valid && o_ready;
    assign o_push   = accept;
    assign o_word   = i_word;
    assign level_ok = {1'b0, i_level} < LEVEL_END;
    assign idx      = i_level[IDX_W-1:0];
    assign cur_head  = r_head[idx];
    assign cur_count = r_count[idx];

    always_comb begin
        tail_sum = SUM_W'(cur_head) + SUM_W'(cur_count);
        next_sum = SUM_W'(cur_head) + SUM_W'(1);
        if (tail_sum >= SUM_W'(DEPTH)) begin
            tail_slot = HEAD_W'(tail_sum - SUM_W'(DEPTH));
        end else begin
            tail_slot = HEAD_W'(tail_sum);
        end
        if (next_sum >= SUM_W'(DEPTH)) begin
            next_head = HEAD_W'(next_sum - SUM_W'(DEPTH));
        end else begin
            next_head = HEAD_W'(next_sum);
        end
    end

    always_comb begin
        o_job.op     = OP_NONE;
        o_job.status = STATUS_OK;
        slot         = cur_head;
        upd          = 1'b0;
        n_head       = cur_head;
        n_count      = cur_count;
        case (i_cmd)
            CMD_PUSH: begin
                if (!level_ok || cur_count == CNT_W'(DEPTH)) begin
                    o_job.status = STATUS_FULL;
                end else begin
                    o_job.op = OP_WRITE;
                    slot     = tail_slot;
                    upd      = 1'b1;
                    n_count  = cur_count + CNT_W'(1);
                end
            end
            CMD_POP: begin
                if (!level_ok || cur_count == '0) begin
                    o_job.status = STATUS_EMPTY;
                end else begin
                    o_job.op = OP_READ;
                    upd      = 1'b1;
                    n_head   = next_head;
                    n_count  = cur_count - CNT_W'(1);
                end
            end
            default: begin
                o_job.status = STATUS_EMPTY;
            end
        endcase
    end

    assign o_addr = ADDR_W'(idx) * ADDR_W'(DEPTH) + ADDR_W'(slot);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < ACTIVE_LEVELS; i++) begin
                r_head[i]  <= '0;
                r_count[i] <= '0;
            end
        end else if (accept && upd) begin
            r_head[idx]  <= n_head;
            r_count[idx] <= n_count;
        end
    end

endmodule

@@ rtl/ppfq_queue.sv @@
// Short job queue between the front end and the store back end.
`timescale 1ns / 1ps

module ppfq_queue
    import ppfq_pkg::*;
#(
    parameter int WIDTH = 40
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic             o_full,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    localparam int PTR_W  = $clog2(QUEUE_DEPTH);
    localparam int FILL_W = $clog2(QUEUE_DEPTH + 1);

    logic [WIDTH-1:0]  r_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0]  r_wr_ptr;
    logic [PTR_W-1:0]  r_rd_ptr;
    logic [FILL_W-1:0] r_fill;

    assign o_full  = r_fill == FILL_W'(QUEUE_DEPTH);
    assign o_valid = r_fill != '0;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_fill <= r_fill + FILL_W'(1);
            end else if (!i_push && i_pop) begin
                r_fill <= r_fill - FILL_W'(1);
            end
        end
    end

endmodule

@@ rtl/ppfq_back.sv @@
// Back end: word store access and the registered result stage.
`timescale 1ns / 1ps

module ppfq_back
    import ppfq_pkg::*;
#(
    parameter  int MEM_DEPTH = 256,
    localparam int ADDR_W    = $clog2(MEM_DEPTH)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_q_valid,
    input  t_job                i_job,
    input  logic [ADDR_W-1:0]   i_addr,
    input  logic [WORD_W-1:0]   i_word,
    output logic                o_q_pop,
    input  logic                i_out_ready,
    output logic                o_out_valid,
    output logic [WORD_W-1:0]   o_out_word,
    output logic [STATUS_W-1:0] o_out_status
);

    logic [WORD_W-1:0]   r_store [MEM_DEPTH];
    logic [WORD_W-1:0]   r_rd_data;
    logic                r_s1_valid;
    t_job                r_s1_job;
    logic                r_out_valid;
    logic [WORD_W-1:0]   r_out_word;
    logic [STATUS_W-1:0] r_out_status;
    logic                s1_adv;
    logic                issue;

    assign s1_adv  = r_s1_valid && (!r_out_valid || i_out_ready);
    assign issue   = i_q_valid && (!r_s1_valid || s1_adv);
    assign o_q_pop = issue;

    assign o_out_valid  = r_out_valid;
    assign o_out_word   = r_out_word;
    assign o_out_status = r_out_status;

    always_ff @(posedge i_clk) begin
        if (issue && i_job.op == OP_WRITE) begin
            r_store[i_addr] <= i_word;
        end
        if (issue && i_job.op == OP_READ) begin
            r_rd_data <= r_store[i_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_s1_job <= i_job;
        end
        if (s1_adv) begin
            r_out_word   <= (r_s1_job.op == OP_READ) ? r_rd_data : '0;
            r_out_status <= r_s1_job.status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (issue) begin
                r_s1_valid <= 1'b1;
            end else if (s1_adv) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_adv) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

@@ rtl/per_priority_fifo_queue.sv @@
// Top level of the per-priority FIFO queue.
`timescale 1ns / 1ps

// Each priority level owns a FIFO of up to DEPTH 32-bit words in one shared
// word store. A push appends to the named level, a pop returns the oldest
// word of that level, and every item yields exactly one result: status ok,
// empty (pop of an empty or absent level, word zero) or full (push dropped,
// word zero). The block takes one item per cycle when the result side keeps
// up; a result passes through the four-entry job queue and the registered
// read of the single-port word store, and then waits in the output register.
// Only levels 0 to 15 are reachable, so at most sixteen FIFOs exist.
// The word store is not cleared; a pop only ever reads words already pushed.

module per_priority_fifo_queue
    import ppfq_pkg::*;
#(
    parameter int LEVELS = 16,
    parameter int DEPTH  = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                s_axis_tvalid,
    output logic                s_axis_tready,
    input  logic [39:0]         s_axis_tdata,  // level[3:0], push_word[35:4], zero fill
    input  logic                s_axis_tuser,  // cmd[0]
    output logic                m_axis_tvalid,
    input  logic                m_axis_tready,
    output logic [WORD_W-1:0]   m_axis_tdata,  // pop_word[31:0]
    output logic [STATUS_W-1:0] m_axis_tuser   // status[1:0]
);

    localparam int ACTIVE_LEVELS = (LEVELS < LEVEL_LIMIT) ? LEVELS : LEVEL_LIMIT;
    localparam int MEM_DEPTH     = ACTIVE_LEVELS * DEPTH;
    localparam int ADDR_W        = $clog2(MEM_DEPTH);
    localparam int JOB_W         = $bits(t_job);
    localparam int ENTRY_W       = JOB_W + ADDR_W + WORD_W;

    logic                f_push;
    t_job                f_job;
    logic [ADDR_W-1:0]   f_addr;
    logic [WORD_W-1:0]   f_word;
    logic                q_full;
    logic                q_valid;
    logic                q_pop;
    logic [ENTRY_W-1:0]  q_data;
    t_job                q_job;

    ppfq_front #(
        .ACTIVE_LEVELS(ACTIVE_LEVELS),
        .DEPTH        (DEPTH)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid),
        .i_cmd   (s_axis_tuser),
        .i_level (s_axis_tdata[LEVEL_W-1:0]),
        .i_word  (s_axis_tdata[LEVEL_W+WORD_W-1:LEVEL_W]),
        .i_q_full(q_full),
        .o_ready (s_axis_tready),
        .o_push  (f_push),
        .o_job   (f_job),
        .o_addr  (f_addr),
        .o_word  (f_word)
    );

    ppfq_queue #(
        .WIDTH(ENTRY_W)
    ) u_queue (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (f_push),
        .i_data ({f_job, f_addr, f_word}),
        .i_pop  (q_pop),
        .o_full (q_full),
        .o_valid(q_valid),
        .o_data (q_data)
    );

    assign q_job = t_job'(q_data[ENTRY_W-1:ADDR_W+WORD_W]);

    ppfq_back #(
        .MEM_DEPTH(MEM_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_job       (q_job),
        .i_addr      (q_data[ADDR_W+WORD_W-1:WORD_W]),
        .i_word      (q_data[WORD_W-1:0]),
        .o_q_pop     (q_pop),
        .i_out_ready (m_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .o_out_word  (m_axis_tdata),
        .o_out_status(m_axis_tuser)
    );

endmodule

@@ rtl/ppfq_checker.sv @@
// Port-level checks of the per-priority FIFO queue and their binding.
`timescale 1ns / 1ps

module ppfq_checker
    import ppfq_pkg::*;
(
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                m_axis_tvalid,
    input logic                m_axis_tready,
    input logic [WORD_W-1:0]   m_axis_tdata,
    input logic [STATUS_W-1:0] m_axis_tuser
);

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("Result item withdrawn while stalled.");

    a_payload_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("Result item changed while stalled.");

    a_fail_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != STATUS_OK |-> m_axis_tdata == '0)
        else $error("Failed item returned a nonzero word.");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("Result item shown right after reset.");

endmodule

bind per_priority_fifo_queue ppfq_checker u_ppfq_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
);
